// ----- hw/rtl/sqtc_pkg.sv -----
// Shared types and constants for the square transposition cipher block.
package sqtc_pkg;

    localparam int CHAR_W = 8;
    localparam int CNT_W  = 6;
    localparam int DIM_W  = 4;
    localparam int MODE_W = 2;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROWS   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CIPHER = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PADDED = 2'd3;

    // register select is paddr[2]; one register only
    localparam logic REG_OUTPUT_MODE = 1'b0;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_BIT   = 8'h20;

    typedef struct packed {
        logic [CHAR_W-1:0] in_char;
        logic              in_last;
    } text_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              group_end;
        logic              out_last;
        logic              overflow;
    } cipher_item_t;

    // classified byte handed from front to back
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              keep;
        logic              last;
    } class_item_t;

endpackage

// ----- hw/rtl/square_transposition_cipher_top.sv -----
// Top level of the square transposition cipher: register port, front and back ends.
//
//  channel  | handshake                         | payload
//  ---------+-----------------------------------+------------------------------
//  text     | text_valid / text_ready           | text (in_char, in_last)
//  cipher   | cipher_valid / cipher_ready       | cipher (out_char, group_end,
//           |                                   |   out_last, overflow)
//  config   | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
// Loading takes one byte transfer per cycle while the two-entry queue has room.
// After the last byte the back end sizes the square, then emits each output character by a
// store read followed by an output register load, held while the output register is full and cipher_ready is low.
// Reset clears the character count, the overflow flag and the queue; output_mode resets to 3.
// Bytes keep flowing into the queue while the back end emits; text_ready drops when it fills.
module square_transposition_cipher_top
#(
    parameter int MAX_CHARS = 48
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sqtc_pkg::ADDR_W-1:0]   paddr,
    input  logic [sqtc_pkg::DATA_W-1:0]   pwdata,
    output logic [sqtc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          text_valid,
    output logic                          text_ready,
    input  sqtc_pkg::text_item_t          text,
    output logic                          cipher_valid,
    input  logic                          cipher_ready,
    output sqtc_pkg::cipher_item_t        cipher
);

    logic [sqtc_pkg::MODE_W-1:0] mode_reg;
    logic [sqtc_pkg::MODE_W-1:0] mode_next;
    logic                        reg_sel;
    logic                        q_valid;
    logic                        q_pop;
    sqtc_pkg::class_item_t       q_item;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[sqtc_pkg::ADDR_W-1] == sqtc_pkg::REG_OUTPUT_MODE);
    assign prdata  = reg_sel ? {{(sqtc_pkg::DATA_W-sqtc_pkg::MODE_W){1'b0}}, mode_reg} : '0;

    always_comb
    begin
        mode_next = mode_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            mode_next = pwdata[sqtc_pkg::MODE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= sqtc_pkg::MODE_PADDED;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    sqtc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text       (text),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    sqtc_back
    #(
        .MAX_CHARS (MAX_CHARS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .output_mode  (mode_reg),
        .cipher_valid (cipher_valid),
        .cipher_ready (cipher_ready),
        .cipher       (cipher)
    );

endmodule

// ----- hw/rtl/sqtc_front.sv -----
// Front end: accepts text bytes, filters and folds them, queues them for the back end.
module sqtc_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 text_valid,
    output logic                 text_ready,
    input  sqtc_pkg::text_item_t text,
    output logic                 q_valid,
    output sqtc_pkg::class_item_t q_item,
    input  logic                 q_pop
);

    sqtc_pkg::class_item_t slot_reg [2];
    logic                  wr_ptr_reg;
    logic                  wr_ptr_next;
    logic                  rd_ptr_reg;
    logic                  rd_ptr_next;
    logic [1:0]            fill_reg;
    logic [1:0]            fill_next;
    sqtc_pkg::class_item_t cls;
    logic                  is_digit;
    logic                  is_upper;
    logic                  is_lower;
    logic                  push;
    logic                  pop;

    always_comb
    begin
        is_digit = (text.in_char >= sqtc_pkg::CHAR_0)  && (text.in_char <= sqtc_pkg::CHAR_9);
        is_upper = (text.in_char >= sqtc_pkg::CHAR_UA) && (text.in_char <= sqtc_pkg::CHAR_UZ);
        is_lower = (text.in_char >= sqtc_pkg::CHAR_LA) && (text.in_char <= sqtc_pkg::CHAR_LZ);
        cls.ch   = is_upper ? (text.in_char | sqtc_pkg::CASE_BIT) : text.in_char;
        cls.keep = is_digit || is_upper || is_lower;
        cls.last = text.in_last;
    end

    assign text_ready = (fill_reg != 2'd2);
    assign q_valid    = (fill_reg != 2'd0);
    assign q_item     = slot_reg[rd_ptr_reg];

    // bytes that are dropped and not last never enter the queue
    assign push = text_valid && text_ready && (cls.keep || cls.last);
    assign pop  = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ----- hw/rtl/sqtc_back.sv -----
// Back end: stores kept characters, sizes the square and emits the chosen output form.
module sqtc_back
#(
    parameter int MAX_CHARS = 48
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  sqtc_pkg::class_item_t         q_item,
    output logic                          q_pop,
    input  logic [sqtc_pkg::MODE_W-1:0]   output_mode,
    output logic                          cipher_valid,
    input  logic                          cipher_ready,
    output sqtc_pkg::cipher_item_t        cipher
);

    localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam logic [sqtc_pkg::CNT_W-1:0] CNT_MAX = sqtc_pkg::CNT_W'(MAX_CHARS);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SIZE = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_PUT  = 2'd3;

    logic [sqtc_pkg::CHAR_W-1:0] mem [MAX_CHARS];
    logic [sqtc_pkg::CHAR_W-1:0] mem_q;

    logic [1:0]                  state_reg,  state_next;
    logic [sqtc_pkg::CNT_W-1:0]  cnt_reg,    cnt_next;
    logic                        drop_reg,   drop_next;
    logic [sqtc_pkg::MODE_W-1:0] mode_reg,   mode_next;
    logic [sqtc_pkg::DIM_W-1:0]  c_reg,      c_next;
    logic [sqtc_pkg::DIM_W-1:0]  r_reg,      r_next;
    logic [sqtc_pkg::DIM_W-1:0]  row_reg,    row_next;
    logic [sqtc_pkg::DIM_W-1:0]  col_reg,    col_next;
    logic [sqtc_pkg::CNT_W-1:0]  idx_reg,    idx_next;
    logic                        sep_reg,    sep_next;
    logic                        out_valid_reg, out_valid_next;
    sqtc_pkg::cipher_item_t      out_reg;

    logic                        wr_en;
    logic                        rd_en;
    logic                        load_out;
    logic                        out_free;
    logic [sqtc_pkg::CNT_W-1:0]  n_total;
    logic [2*sqtc_pkg::DIM_W-1:0] c_sq;
    logic [2*sqtc_pkg::DIM_W-1:0] c_cm1;
    logic [2*sqtc_pkg::DIM_W-1:0] n_wide;
    logic                        last_idx;
    logic                        col_end;
    logic                        row_end;
    logic                        past_end;
    logic                        idx_in;
    sqtc_pkg::cipher_item_t      item;
    logic                        col_step;

    assign out_free     = !out_valid_reg || cipher_ready;
    assign cipher_valid = out_valid_reg;
    assign cipher       = out_reg;

    always_comb
    begin
        c_sq     = c_reg * c_reg;
        c_cm1    = c_reg * (c_reg - sqtc_pkg::DIM_W'(1));
        n_wide   = {{(2*sqtc_pkg::DIM_W-sqtc_pkg::CNT_W){1'b0}}, cnt_reg};
        last_idx = (idx_reg == cnt_reg - sqtc_pkg::CNT_W'(1));
        col_end  = (col_reg == c_reg - sqtc_pkg::DIM_W'(1));
        row_end  = (row_reg == r_reg - sqtc_pkg::DIM_W'(1));
        past_end = ({1'b0, idx_reg} + {3'b000, c_reg}) >= {1'b0, cnt_reg};
        idx_in   = (idx_reg < cnt_reg);
    end

    // output item and column step for the current cursor position
    always_comb
    begin
        item.out_char  = mem_q;
        item.group_end = 1'b0;
        item.out_last  = 1'b0;
        item.overflow  = drop_reg;
        col_step       = 1'b0;
        case (mode_reg)
            sqtc_pkg::MODE_NORMAL:
            begin
                item.out_last = last_idx;
            end
            sqtc_pkg::MODE_ROWS:
            begin
                item.group_end = col_end || last_idx;
                item.out_last  = last_idx;
            end
            sqtc_pkg::MODE_CIPHER:
            begin
                item.group_end = row_end || past_end;
                item.out_last  = col_end && (row_end || past_end);
                col_step       = row_end || past_end;
            end
            default:
            begin
                if (sep_reg)
                begin
                    item.out_char = sqtc_pkg::CHAR_SPACE;
                end
                else
                begin
                    item.out_char  = idx_in ? mem_q : sqtc_pkg::CHAR_SPACE;
                    item.group_end = row_end;
                    item.out_last  = col_end && row_end;
                    col_step       = row_end;
                end
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        drop_next      = drop_reg;
        mode_next      = mode_reg;
        c_next         = c_reg;
        r_next         = r_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        idx_next       = idx_reg;
        sep_next       = sep_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        load_out       = 1'b0;
        n_total        = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && cipher_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_item.keep)
                    begin
                        if (cnt_reg < CNT_MAX)
                        begin
                            wr_en    = 1'b1;
                            n_total  = cnt_reg + sqtc_pkg::CNT_W'(1);
                            cnt_next = n_total;
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                    end
                    if (q_item.last)
                    begin
                        if (n_total == '0)
                        begin
                            cnt_next  = '0;
                            drop_next = 1'b0;
                        end
                        else
                        begin
                            c_next     = sqtc_pkg::DIM_W'(1);
                            mode_next  = output_mode;
                            state_next = ST_SIZE;
                        end
                    end
                end
            end
            ST_SIZE:
            begin
                if (c_sq >= n_wide)
                begin
                    r_next     = (n_wide > c_cm1) ? c_reg : c_reg - sqtc_pkg::DIM_W'(1);
                    row_next   = '0;
                    col_next   = '0;
                    idx_next   = '0;
                    sep_next   = 1'b0;
                    state_next = ST_READ;
                end
                else
                begin
                    c_next = c_reg + sqtc_pkg::DIM_W'(1);
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_READ;
                    if (mode_reg == sqtc_pkg::MODE_NORMAL || mode_reg == sqtc_pkg::MODE_ROWS)
                    begin
                        idx_next = idx_reg + sqtc_pkg::CNT_W'(1);
                        col_next = col_end ? '0 : col_reg + sqtc_pkg::DIM_W'(1);
                    end
                    else if (mode_reg == sqtc_pkg::MODE_PADDED && sep_reg)
                    begin
                        sep_next = 1'b0;
                    end
                    else if (col_step)
                    begin
                        col_next = col_reg + sqtc_pkg::DIM_W'(1);
                        row_next = '0;
                        idx_next = {{(sqtc_pkg::CNT_W-sqtc_pkg::DIM_W){1'b0}}, col_reg}
                                   + sqtc_pkg::CNT_W'(1);
                        sep_next = (mode_reg == sqtc_pkg::MODE_PADDED);
                    end
                    else
                    begin
                        row_next = row_reg + sqtc_pkg::DIM_W'(1);
                        idx_next = idx_reg
                                   + {{(sqtc_pkg::CNT_W-sqtc_pkg::DIM_W){1'b0}}, c_reg};
                    end
                    if (item.out_last)
                    begin
                        cnt_next   = '0;
                        drop_next  = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            drop_reg      <= 1'b0;
            mode_reg      <= sqtc_pkg::MODE_PADDED;
            c_reg         <= '0;
            r_reg         <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            idx_reg       <= '0;
            sep_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            drop_reg      <= drop_next;
            mode_reg      <= mode_next;
            c_reg         <= c_next;
            r_reg         <= r_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            idx_reg       <= idx_next;
            sep_reg       <= sep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= item;
        end
    end

    // text store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cnt_reg[AW-1:0]] <= q_item.ch;
        end
        if (rd_en)
        begin
            mem_q <= mem[idx_reg[AW-1:0]];
        end
    end

endmodule

// ----- tb/sv/square_cipher_checker.sv -----
// Watches the text, cipher and register ports, predicts the cipher stream and compares it.
`timescale 1ns / 100ps

module square_cipher_checker
#(
    parameter int MAX_CHARS = 48
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [sqtc_pkg::ADDR_W-1:0] paddr,
    input  logic [sqtc_pkg::DATA_W-1:0] pwdata,
    input  logic                        text_valid,
    input  logic                        text_ready,
    input  sqtc_pkg::text_item_t        text,
    input  logic                        cipher_valid,
    input  logic                        cipher_ready,
    input  sqtc_pkg::cipher_item_t      cipher,
    output int                          backlog,
    output int                          mismatches,
    output int                          results_seen
);

    logic [sqtc_pkg::CHAR_W-1:0] letters [MAX_CHARS];
    int unsigned                 letter_count;
    bit                          chars_dropped;
    logic [sqtc_pkg::MODE_W-1:0] cipher_mode;
    sqtc_pkg::cipher_item_t      expected_cipher [$];
    sqtc_pkg::cipher_item_t      want;
    int                          fail_count;
    int                          result_count;

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("%t mismatch on cipher transfer %0d: %s", $realtime, result_count, what);
    endtask

    task automatic push_char(input logic [sqtc_pkg::CHAR_W-1:0] ch, input logic gend);
        sqtc_pkg::cipher_item_t item;
        item.out_char  = ch;
        item.group_end = gend;
        item.out_last  = 1'b0;
        item.overflow  = chars_dropped;
        expected_cipher.insert(expected_cipher.size(), item);
    endtask

    task automatic predict_cipher(input sqtc_pkg::text_item_t t);
        logic [sqtc_pkg::CHAR_W-1:0] ch;
        int unsigned                 cols;
        int unsigned                 rows;
        int unsigned                 col;
        int unsigned                 row;
        int unsigned                 idx;
        int                          first;
        ch = t.in_char;
        if ((ch >= sqtc_pkg::CHAR_0 && ch <= sqtc_pkg::CHAR_9) ||
            (ch >= sqtc_pkg::CHAR_LA && ch <= sqtc_pkg::CHAR_LZ) ||
            (ch >= sqtc_pkg::CHAR_UA && ch <= sqtc_pkg::CHAR_UZ))
        begin
            if (ch >= sqtc_pkg::CHAR_UA && ch <= sqtc_pkg::CHAR_UZ)
                ch = ch | sqtc_pkg::CASE_BIT;
            if (letter_count < MAX_CHARS)
            begin
                letters[letter_count] = ch;
                letter_count++;
            end
            else
                chars_dropped = 1'b1;
        end
        if (!t.in_last)
            return;
        first = expected_cipher.size();
        if (letter_count > 0)
        begin
            // smallest square that holds the text, then widen until rows fit
            cols = 1;
            while (cols * cols < letter_count)
                cols++;
            while (cols < 64)
            begin
                rows = (letter_count + cols - 1) / cols;
                if (cols >= rows && cols - rows <= 1)
                    break;
                cols++;
            end
            rows = (letter_count + cols - 1) / cols;
            case (cipher_mode)
                sqtc_pkg::MODE_NORMAL:
                    for (idx = 0; idx < letter_count; idx++)
                        push_char(letters[idx], 1'b0);
                sqtc_pkg::MODE_ROWS:
                    for (idx = 0; idx < letter_count; idx++)
                        push_char(letters[idx],
                                  (idx % cols == cols - 1) || (idx == letter_count - 1));
                sqtc_pkg::MODE_CIPHER:
                    for (col = 0; col < cols; col++)
                        for (row = 0; row < rows; row++)
                        begin
                            idx = row * cols + col;
                            if (idx < letter_count)
                                push_char(letters[idx], (row + 1 >= rows) ||
                                          ((row + 1) * cols + col >= letter_count));
                        end
                default:
                    for (col = 0; col < cols; col++)
                    begin
                        if (col != 0)
                            push_char(sqtc_pkg::CHAR_SPACE, 1'b0);
                        for (row = 0; row < rows; row++)
                        begin
                            idx = row * cols + col;
                            push_char(idx < letter_count ? letters[idx] : sqtc_pkg::CHAR_SPACE,
                                      row + 1 == rows);
                        end
                    end
            endcase
            if (expected_cipher.size() > first)
                expected_cipher[expected_cipher.size() - 1].out_last = 1'b1;
        end
        letter_count  = 0;
        chars_dropped = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_mode   = sqtc_pkg::MODE_PADDED;
            letter_count  = 0;
            chars_dropped = 1'b0;
            expected_cipher.delete();
            fail_count    = 0;
            result_count  = 0;
            backlog      <= 0;
            mismatches   <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready &&
                paddr[sqtc_pkg::ADDR_W-1] == sqtc_pkg::REG_OUTPUT_MODE)
                cipher_mode = pwdata[sqtc_pkg::MODE_W-1:0];
            if (cipher_valid && cipher_ready)
            begin
                result_count++;
                if (expected_cipher.size() == 0)
                    report_mismatch($sformatf("unexpected transfer, char %h", cipher.out_char));
                else
                begin
                    want = expected_cipher.pop_front();
                    if (cipher.out_char !== want.out_char)
                        report_mismatch($sformatf("out_char %h, want %h",
                                                  cipher.out_char, want.out_char));
                    if (cipher.group_end !== want.group_end)
                        report_mismatch($sformatf("group_end %b, want %b",
                                                  cipher.group_end, want.group_end));
                    if (cipher.out_last !== want.out_last)
                        report_mismatch($sformatf("out_last %b, want %b",
                                                  cipher.out_last, want.out_last));
                    if (cipher.overflow !== want.overflow)
                        report_mismatch($sformatf("overflow %b, want %b",
                                                  cipher.overflow, want.overflow));
                end
            end
            if (text_valid && text_ready)
                predict_cipher(text);
            backlog      <= expected_cipher.size();
            mismatches   <= fail_count;
            results_seen <= result_count;
        end
    end

endmodule

// ----- tb/sv/tb_square_transposition_cipher_top.sv -----
// Stimulus, clock, reset and verdict for the square transposition cipher block.
`timescale 1ns / 100ps

module tb_square_transposition_cipher_top;

    localparam int MAX_CHARS     = 48;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 48;

    localparam logic [sqtc_pkg::ADDR_W-1:0] MODE_ADDR  = {sqtc_pkg::REG_OUTPUT_MODE, 2'b00};
    localparam logic [sqtc_pkg::ADDR_W-1:0] SPARE_ADDR = {~sqtc_pkg::REG_OUTPUT_MODE, 2'b00};

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [sqtc_pkg::ADDR_W-1:0] paddr;
    logic [sqtc_pkg::DATA_W-1:0] pwdata;
    logic [sqtc_pkg::DATA_W-1:0] prdata;
    logic                        pready;
    logic                        text_valid;
    logic                        text_ready;
    sqtc_pkg::text_item_t        text;
    logic                        cipher_valid;
    logic                        cipher_ready;
    sqtc_pkg::cipher_item_t      cipher;

    int backlog;
    int mismatches;
    int results_seen;
    int burst_left;
    int items_sent;
    int messages;
    int idle_cycles;
    int phase;
    int phase_start;

    square_transposition_cipher_top #(
        .MAX_CHARS (MAX_CHARS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .text         (text),
        .cipher_valid (cipher_valid),
        .cipher_ready (cipher_ready),
        .cipher       (cipher)
    );

    square_cipher_checker #(
        .MAX_CHARS (MAX_CHARS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .text         (text),
        .cipher_valid (cipher_valid),
        .cipher_ready (cipher_ready),
        .cipher       (cipher),
        .backlog      (backlog),
        .mismatches   (mismatches),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (text_valid && text_ready) || (cipher_valid && cipher_ready) ||
            (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[square_transposition_cipher_top] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // receiver: rotating ready masks, with the odd long stall
    initial
    begin
        logic [7:0]  mask;
        int          hold;
        int unsigned slot;
        cipher_ready <= 1'b0;
        hold = 0;
        slot = 0;
        mask = 8'hFF;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                case ($urandom_range(0, 4))
                    0: mask = 8'hFF;
                    1: mask = 8'($urandom) | 8'h01;
                    2: mask = 8'($urandom | $urandom) | 8'h10;
                    3: mask = 8'h01;
                    default: mask = 8'h00;
                endcase
                hold = (mask == 8'h00) ? $urandom_range(5, 25) : $urandom_range(16, 96);
            end
            hold--;
            cipher_ready <= mask[slot % 8];
            slot++;
        end
    end

    task automatic write_reg(input logic [sqtc_pkg::ADDR_W-1:0] addr,
                             input logic [sqtc_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_mode(input logic [sqtc_pkg::MODE_W-1:0] mode);
        logic [sqtc_pkg::DATA_W-1:0] data;
        data = $urandom;
        data[sqtc_pkg::MODE_W-1:0] = mode;
        write_reg(MODE_ADDR, data);
    endtask

    task automatic send_byte(input logic [sqtc_pkg::CHAR_W-1:0] ch, input logic last);
        int gap;
        if (burst_left == 0)
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(24, 64)
                                                     : $urandom_range(1, 12);
        text_valid <= 1'b1;
        text       <= {ch, last};
        @(posedge clk);
        while (!text_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
        burst_left--;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                text_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic send_string(input string s, input logic ends);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], ends && (i == s.len() - 1));
        if (ends)
            messages++;
    endtask

    // kinds: text with some punctuation, raw noise, nothing kept, long letters and digits that may overflow
    task automatic send_message(input int kind);
        int                          len;
        int                          i;
        logic [sqtc_pkg::CHAR_W-1:0] ch;
        case (kind)
            0:       len = $urandom_range(1, 20);
            1:       len = $urandom_range(1, 12);
            2:       len = $urandom_range(1, 3);
            default: len = $urandom_range(44, 58);
        endcase
        for (i = 0; i < len; i++)
        begin
            case (kind)
                1: ch = sqtc_pkg::CHAR_W'($urandom_range(0, 255));
                2: ch = $urandom_range(0, 1) ? sqtc_pkg::CHAR_W'($urandom_range(8'h80, 8'hFF))
                                             : sqtc_pkg::CHAR_W'($urandom_range(8'h20, 8'h2F));
                default:
                    case ($urandom_range(0, (kind == 0) ? 9 : 8))
                        0, 1, 2, 3: ch = sqtc_pkg::CHAR_LA
                                         + sqtc_pkg::CHAR_W'($urandom_range(0, 25));
                        4, 5, 6:    ch = sqtc_pkg::CHAR_UA
                                         + sqtc_pkg::CHAR_W'($urandom_range(0, 25));
                        7, 8:       ch = sqtc_pkg::CHAR_0
                                         + sqtc_pkg::CHAR_W'($urandom_range(0, 9));
                        default:    ch = sqtc_pkg::CHAR_W'($urandom_range(8'h20, 8'h2F));
                    endcase
            endcase
            send_byte(ch, i == len - 1);
        end
        messages++;
    endtask

    task automatic wait_for_results();
        if (text_valid)
            text_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int pick;
        rst_n      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        text_valid <= 1'b0;
        text       <= '0;
        burst_left  = 0;
        items_sent  = 0;
        messages    = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset mode: padded columns, field extremes and class boundaries
        send_string("Z0", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_string("a@9[m`:", 1'b0);
        send_byte(8'h00, 1'b1);
        messages++;
        send_string(" ", 1'b1);
        wait_for_results();
        set_mode(sqtc_pkg::MODE_NORMAL);
        send_string("K7", 1'b1);
        wait_for_results();
        set_mode(sqtc_pkg::MODE_ROWS);
        send_string("abcde", 1'b1);
        wait_for_results();
        set_mode(sqtc_pkg::MODE_CIPHER);
        send_string("wxyz1", 1'b1);

        for (phase = 0; phase < 6; phase++)
        begin
            wait_for_results();
            case (phase)
                0:       set_mode(sqtc_pkg::MODE_PADDED);
                1:       set_mode(sqtc_pkg::MODE_NORMAL);
                2:       set_mode(sqtc_pkg::MODE_ROWS);
                3:       set_mode(sqtc_pkg::MODE_CIPHER);
                default: set_mode(sqtc_pkg::MODE_W'($urandom_range(0, 3)));
            endcase
            if (phase == 2)
                write_reg(SPARE_ADDR, $urandom);
            phase_start = items_sent;
            if (phase == 0)
                send_message(3);
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 19);
                send_message(pick < 14 ? 0 : pick < 17 ? 1 : pick < 19 ? 2 : 3);
            end
        end

        wait_for_results();
        $display("Run covered %0d text transfers in %0d messages and %0d cipher transfers,",
                 items_sent, messages, results_seen);
        $display("with all four output modes, overflow, empty and non-ASCII text.");
        if (mismatches == 0 && backlog == 0)
            $display("[square_transposition_cipher_top] OK");
        else
            $display("[square_transposition_cipher_top] ERROR");
        $finish;
    end

endmodule
